[rtl/deq_pkg.sv]
// Shared types and constants for the double-ended queue with delete by value.
package deq_pkg;

   localparam int DEFAULT_CAPACITY   = 16;
   localparam int DEFAULT_VALUE_BITS = 32;
   localparam int FIELD_BITS         = 32;
   localparam int OCC_BITS           = 5;

   localparam logic signed [FIELD_BITS-1:0] POPPED_NONE = '1;

   typedef enum logic [2:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_POP_BACK   = 3'd1,
      CMD_PUSH_FRONT = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_DELETE     = 3'd4
   } cmd_type;

   typedef struct packed {
      logic [2:0]                   cmd;
      logic signed [FIELD_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] popped;
      logic                         was_empty;
      logic                         was_full;
      logic                         found;
      logic [OCC_BITS-1:0]          occupancy;
   } rsp_type;

   // per-cycle operation broadcast to every cell, already qualified
   typedef struct packed {
      logic push_back;
      logic pop_back;
      logic push_front;
      logic pop_front;
      logic del_match;
   } cell_ctrl_type;

endpackage

[rtl/deque_with_delete_by_value.sv]
// Latency: a result beat appears the cycle after its request beat is taken.
// Throughput: one command per cycle, delete included, while results drain; the
// row of cells shifts in one step and the first-match flag ripples cell to cell.
// Reset: synchronous, active high; clears all valid bits, the count and the
// response valid flag. Entry data and the response payload are not reset.
module deque_with_delete_by_value import deq_pkg::*; #(
   parameter int CAPACITY   = DEFAULT_CAPACITY,
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int WW = CW + OCC_BITS;

   logic [VALUE_BITS-1:0] cell_data [CAPACITY];
   logic [CAPACITY-1:0]   cell_valid;
   logic [CAPACITY:0]     match_chain;
   logic [CW-1:0]         count_ff, count_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  fire, full, empty, found;
   logic [VALUE_BITS-1:0] value;
   logic [VALUE_BITS-1:0] back_data;
   cell_ctrl_type         ctrl;
   logic [WW-1:0]         occ_ext;

   assign fire      = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign value     = VALUE_BITS'($signed(req_data.value));
   assign found     = match_chain[CAPACITY];

   always_comb begin
      ctrl            = '0;
      ctrl.push_back  = fire && (req_data.cmd == CMD_PUSH_BACK) && !full;
      ctrl.push_front = fire && (req_data.cmd == CMD_PUSH_FRONT) && !full;
      ctrl.pop_back   = fire && (req_data.cmd == CMD_POP_BACK) && !empty;
      ctrl.pop_front  = fire && (req_data.cmd == CMD_POP_FRONT) && !empty;
      ctrl.del_match  = fire && (req_data.cmd == CMD_DELETE);
   end

   assign match_chain[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_BITS-1:0] l_data, r_data;
      logic                  l_valid, r_valid;
      if (i == 0) begin : g_first
         assign l_data  = value;
         assign l_valid = 1'b1;
      end else begin : g_mid_l
         assign l_data  = cell_data[i-1];
         assign l_valid = cell_valid[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign r_data  = '0;
         assign r_valid = 1'b0;
      end else begin : g_mid_r
         assign r_data  = cell_data[i+1];
         assign r_valid = cell_valid[i+1];
      end
      deq_cell #(
         .VALUE_BITS(VALUE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .value      (value),
         .left_data  (l_data),
         .left_valid (l_valid),
         .right_data (r_data),
         .right_valid(r_valid),
         .match_in   (match_chain[i]),
         .match_out  (match_chain[i+1]),
         .data       (cell_data[i]),
         .valid      (cell_valid[i])
      );
   end

   // back entry: the valid cell whose right neighbor is empty
   always_comb begin
      back_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_valid[i] && ((i == CAPACITY - 1) || !cell_valid[(i + 1) % CAPACITY])) begin
            back_data = back_data | cell_data[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.push_back || ctrl.push_front) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop_back || ctrl.pop_front || (ctrl.del_match && found)) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign occ_ext = WW'(count_in);

   always_comb begin
      rsp_in           = '0;
      rsp_in.popped    = POPPED_NONE;
      rsp_in.occupancy = occ_ext[OCC_BITS-1:0];
      case (req_data.cmd)
         CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
            rsp_in.was_full = full;
         end
         CMD_POP_BACK: begin
            rsp_in.was_empty = empty;
            if (!empty) begin
               rsp_in.popped = FIELD_BITS'($signed(back_data));
            end
         end
         CMD_POP_FRONT: begin
            rsp_in.was_empty = empty;
            if (!empty) begin
               rsp_in.popped = FIELD_BITS'($signed(cell_data[0]));
            end
         end
         CMD_DELETE: begin
            rsp_in.found = found;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("count does not match valid cells");

   a_cells_packed: assert property (@(posedge clock) disable iff (reset)
      (cell_valid & (cell_valid + 1'b1)) == '0)
      else $error("valid cells not packed at the front");

   a_no_both_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.was_empty && rsp_data.was_full))
      else $error("empty and full flagged together");

   a_delete_step: assert property (@(posedge clock) disable iff (reset)
      (ctrl.del_match && found) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("delete hit did not shrink the queue");
`endif

endmodule

[rtl/deq_cell.sv]
// One queue slot: holds an entry and its valid bit, shifts with its neighbors.
module deq_cell import deq_pkg::*; #(
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctrl_type         ctrl,
   input  logic [VALUE_BITS-1:0] value,
   input  logic [VALUE_BITS-1:0] left_data,
   input  logic                  left_valid,
   input  logic [VALUE_BITS-1:0] right_data,
   input  logic                  right_valid,
   input  logic                  match_in,
   output logic                  match_out,
   output logic [VALUE_BITS-1:0] data,
   output logic                  valid
);

   logic [VALUE_BITS-1:0] data_ff, data_in;
   logic                  valid_ff, valid_in;
   logic                  hit;

   assign hit       = valid_ff && (data_ff == value);
   assign match_out = match_in || hit;
   assign data      = data_ff;
   assign valid     = valid_ff;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctrl.push_back && !valid_ff && left_valid) begin
         data_in  = value;
         valid_in = 1'b1;
      end
      if (ctrl.push_front) begin
         data_in  = left_data;
         valid_in = left_valid;
      end
      if (ctrl.pop_back && valid_ff && !right_valid) begin
         valid_in = 1'b0;
      end
      if (ctrl.pop_front || (ctrl.del_match && (match_in || hit))) begin
         data_in  = right_data;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

[test/deque_checker.sv]
// Checker for the deque: predicts each result beat from the request beats and compares.
module deque_checker import deq_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      outstanding,
   output int      checked,
   output int      full_drops,
   output int      empty_pops,
   output int      delete_hits
);
   timeunit 1ns;
   timeprecision 1ps;

   logic signed [FIELD_BITS-1:0] held_values[$];
   rsp_type                      expected_results[$];

   function automatic rsp_type apply_command(req_type beat);
      rsp_type want;
      bit      hit;
      want.popped    = POPPED_NONE;
      want.was_empty = 1'b0;
      want.was_full  = 1'b0;
      want.found     = 1'b0;
      case (beat.cmd)
         CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
            if (held_values.size() >= CAPACITY) begin
               want.was_full = 1'b1;
               full_drops++;
            end else if (beat.cmd == CMD_PUSH_BACK) begin
               held_values.push_back(beat.value);
            end else begin
               held_values.push_front(beat.value);
            end
         end
         CMD_POP_BACK, CMD_POP_FRONT: begin
            if (held_values.size() == 0) begin
               want.was_empty = 1'b1;
               empty_pops++;
            end else if (beat.cmd == CMD_POP_BACK) begin
               want.popped = held_values.pop_back();
            end else begin
               want.popped = held_values.pop_front();
            end
         end
         CMD_DELETE: begin
            hit = 1'b0;
            for (int idx = 0; idx < held_values.size() && !hit; idx++) begin
               if (held_values[idx] == beat.value) begin
                  held_values.delete(idx);
                  hit = 1'b1;
               end
            end
            want.found = hit;
            if (hit) delete_hits++;
         end
         default: ;
      endcase
      want.occupancy = OCC_BITS'(held_values.size());
      return want;
   endfunction

   task automatic compare_field(string field, logic [FIELD_BITS-1:0] want,
                                logic [FIELD_BITS-1:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: result %0d, %s: expected %h, got %h",
                     $realtime, checked, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_results.push_back(apply_command(req_data));
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result beat %h", $realtime, rsp_data);
            end else begin
               want = expected_results.pop_front();
               compare_field("popped", want.popped, rsp_data.popped);
               compare_field("was_empty", FIELD_BITS'(want.was_empty),
                             FIELD_BITS'(rsp_data.was_empty));
               compare_field("was_full", FIELD_BITS'(want.was_full),
                             FIELD_BITS'(rsp_data.was_full));
               compare_field("found", FIELD_BITS'(want.found),
                             FIELD_BITS'(rsp_data.found));
               compare_field("occupancy", FIELD_BITS'(want.occupancy),
                             FIELD_BITS'(rsp_data.occupancy));
            end
         end
      end
      outstanding = expected_results.size();
   end

endmodule

[test/testbench.sv]
// Top of the deque testbench: clock, reset, request and response stimulus, verdict.
module testbench;
   import deq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          RANDOM_ITEMS   = 1700;
   localparam int          HOLD_CYCLES    = 80;
   localparam int          STALL_LIMIT    = 2000;
   localparam logic [2:0]  CMD_UNKNOWN_LO = 3'(CMD_DELETE + 1);
   localparam logic [2:0]  CMD_UNKNOWN_HI = '1;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int fail_count, outstanding, checked, full_drops, empty_pops, delete_hits;
   int send_idle_pct = 21;
   int recv_idle_pct = 62;
   int hold_requests = 0;
   int holds_done    = 0;
   int hold_left     = 0;
   int sent          = 0;
   int stall_cycles  = 0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   deque_with_delete_by_value dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   deque_checker deque_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .checked     (checked),
      .full_drops  (full_drops),
      .empty_pops  (empty_pops),
      .delete_hits (delete_hits)
   );

   // small pool so that deletes find matches and duplicates appear
   function automatic logic signed [FIELD_BITS-1:0] pick_value();
      if ($urandom_range(3) == 0) return $urandom();
      case ($urandom_range(7))
         0: return 0;
         1: return -1;
         2: return 1;
         3: return 32'sh7FFF_FFFF;
         4: return 32'sh8000_0000;
         5: return 32'sh5555_5555;
         6: return 32'shAAAA_AAAA;
         default: return 100;
      endcase
   endfunction

   task automatic issue(logic [2:0] code, logic signed [FIELD_BITS-1:0] operand);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{cmd: code, value: operand};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   // receiver: random stalls, plus long hold-offs on request
   initial begin
      forever begin
         @(negedge clock);
         if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("deque_with_delete_by_value test failed");
            $finish;
         end
      end
   end

   initial begin
      int         phase_end;
      int         choice;
      logic [2:0] code;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty pops, extremes, duplicates, delete hit and miss, unknown codes
      issue(CMD_POP_BACK, 0);
      issue(CMD_POP_FRONT, -1);
      issue(CMD_DELETE, 0);
      issue(CMD_UNKNOWN_LO, 5);
      issue(CMD_PUSH_BACK, 32'sh7FFF_FFFF);
      issue(CMD_PUSH_FRONT, 32'sh8000_0000);
      issue(CMD_PUSH_BACK, -1);
      issue(CMD_PUSH_FRONT, 0);
      issue(CMD_PUSH_BACK, 32'sh8000_0000);
      issue(CMD_DELETE, 32'sh8000_0000);
      issue(CMD_DELETE, 42);
      issue(3'(CMD_UNKNOWN_LO + 1), 32'sh7FFF_FFFF);
      issue(CMD_UNKNOWN_HI, -1);
      issue(CMD_POP_FRONT, 0);
      issue(CMD_POP_BACK, 0);
      issue(CMD_POP_BACK, 0);
      issue(CMD_POP_FRONT, 0);
      issue(CMD_POP_BACK, 0);

      for (int phase = 0; phase < 3; phase++) begin
         wait_drained();
         send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 62 : 0;
         recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 21 : 0;
         hold_requests++;
         phase_end = sent + RANDOM_ITEMS / 3;
         while (sent < phase_end) begin
            choice = $urandom_range(99);
            if (choice < 8) begin
               repeat ($urandom_range(20, 17))
                  issue($urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
            end else if (choice < 16) begin
               repeat ($urandom_range(20, 17))
                  issue($urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK, pick_value());
            end else if (choice < 20) begin
               issue(3'($urandom_range(CMD_UNKNOWN_HI, CMD_UNKNOWN_LO)), $urandom());
            end else begin
               code = 3'($urandom_range(CMD_DELETE, CMD_PUSH_BACK));
               issue(code, pick_value());
            end
         end
      end

      wait_drained();
      repeat (4) @(negedge clock);
      $display("%0d commands over three stall mixes and long output hold-offs, %0d results checked",
               sent, checked);
      $display("%0d pushes into a full queue, %0d pops of an empty queue, %0d deletes that hit",
               full_drops, empty_pops, delete_hits);
      if (fail_count == 0 && outstanding == 0) begin
         $display("deque_with_delete_by_value test passed");
      end else begin
         $display("deque_with_delete_by_value test failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/deque_with_delete_by_value.sv
test/deque_checker.sv
test/testbench.sv
